// ===== rtl/core/c3f_pkg.sv =====
// c3f_pkg: shared types, register indexes and helpers of the 3x3 image filter.
// Used by every module in rtl/core; depends on nothing.
package c3f_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_DIM_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_MIDDLE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_BOTTOM  = 3'd5;

  localparam logic [CFG_DATA_W-1:0] COEF_TOP_RST    = 24'h010201;
  localparam logic [CFG_DATA_W-1:0] COEF_MIDDLE_RST = 24'h020402;
  localparam logic [CFG_DATA_W-1:0] COEF_BOTTOM_RST = 24'h010201;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       flush;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       out_last;
  } out_item_t;

  // Classification of one transaction, decided by the front end.
  typedef struct packed {
    logic emit;
    logic col0;
    logic top;
    logic bottom;
    logic left;
    logic right;
    logic last;
  } c3f_ctrl_t;

  // Pixels are packed red in the low byte, blue in the high byte.
  typedef struct packed {
    logic [23:0] up;
    logic [23:0] mid;
    logic [23:0] pix;
    c3f_ctrl_t   ctrl;
  } c3f_entry_t;

  // Drop negative sums, scale by 1/16, clip at 255.
  function automatic logic [7:0] c3f_saturate(input logic signed [20:0] sum);
    logic [16:0] q;
    q = sum[20:4];
    if (sum[20]) begin
      return 8'd0;
    end else if (q > 17'd255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

endpackage

// ===== rtl/core/conv3x3_image_filter.sv =====
// conv3x3_image_filter: streaming 3x3 convolution with line stores.
// Send pixels of a frame in raster order on the input channel (valid/stall);
// filtered pixels leave in raster order on the output channel (valid/stall).
// The result for pixel (r,c) is due W+1 transactions after that pixel, so
// close each frame with W+1 flush transactions; out_last marks the final one.
// Kernel, size and colour mode come over the write port (index, data, enable);
// the user must change them only while the block is idle; nothing enforces it.
// Throughput: one transaction per clock while in_stall_o is low, set by the
// line store taking one read and one write per transaction; a write to the
// address being read is forwarded. out_valid_o rises once the transaction
// that completes its window has passed the front stage, queue, tap, multiply
// and output registers.
// Reset: all positions and the window clear; a clearing pass then zeroes all
// MAX_WIDTH line-store entries, one entry a cycle, with in_stall_o high.
// A stall on the output holds the back end; the queue absorbs items in flight
// and in_stall_o rises when the queue and front stage hold QUEUE_DEPTH items.
// Depends on c3f_pkg, c3f_front, c3f_queue, c3f_back.
module conv3x3_image_filter
  import c3f_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH+1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT+1);
  localparam int unsigned CW = ((WW > HW) ? WW : HW) > CFG_DIM_W ?
                               ((WW > HW) ? WW : HW) : CFG_DIM_W;
  localparam int unsigned LW = $clog2(QUEUE_DEPTH+1);

  logic [CFG_DIM_W-1:0]  width_q, height_q;
  logic                  mode_q;
  logic [CFG_DATA_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;

  logic [CW-1:0] w_x, h_x;
  logic [WW-1:0] img_w;
  logic [HW-1:0] img_h;

  logic          push, pop, q_valid;
  c3f_entry_t    push_entry, pop_entry;
  logic [LW-1:0] q_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= CFG_DIM_W'(1024);
      height_q   <= CFG_DIM_W'(1024);
      mode_q     <= 1'b0;
      coef_top_q <= COEF_TOP_RST;
      coef_mid_q <= COEF_MIDDLE_RST;
      coef_bot_q <= COEF_BOTTOM_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IMAGE_WIDTH:  width_q    <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_q   <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_COLOUR_MODE:  mode_q     <= cfg_data_i[0];
        CFG_COEF_TOP:     coef_top_q <= cfg_data_i;
        CFG_COEF_MIDDLE:  coef_mid_q <= cfg_data_i;
        CFG_COEF_BOTTOM:  coef_bot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    w_x = CW'(width_q);
    h_x = CW'(height_q);
    if (w_x == '0) begin
      w_x = CW'(1);
    end else if (w_x > CW'(MAX_WIDTH)) begin
      w_x = CW'(MAX_WIDTH);
    end
    if (h_x == '0) begin
      h_x = CW'(1);
    end else if (h_x > CW'(MAX_HEIGHT)) begin
      h_x = CW'(MAX_HEIGHT);
    end
    img_w = w_x[WW-1:0];
    img_h = h_x[HW-1:0];
  end

  c3f_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH      (QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .img_w_i    (img_w),
    .img_h_i    (img_h),
    .q_level_i  (q_level),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  c3f_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .level_o (q_level)
  );

  c3f_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .colour_mode_i (mode_q),
    .coef_top_i    (coef_top_q),
    .coef_middle_i (coef_mid_q),
    .coef_bottom_i (coef_bot_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

// ===== rtl/core/c3f_front.sv =====
// c3f_front: accepts pixels, tracks the raster position, classifies each
// transaction and keeps the two stored lines in one line store. Depends on c3f_pkg.
module c3f_front
  import c3f_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int unsigned DEPTH      = QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  in_item_t                         in_item_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   img_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  img_h_i,
  input  logic [$clog2(DEPTH+1)-1:0]       q_level_i,
  output logic                             push_o,
  output c3f_entry_t                       entry_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH+1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT+1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT+3);
  localparam int unsigned MW = (RW > WW) ? RW : WW;
  localparam int unsigned DW = ((MW > HW) ? MW : HW) + 1;
  localparam int unsigned LW = $clog2(DEPTH+1);

  logic [AW-1:0] ic_q, ic_d;
  logic [RW-1:0] ir_q, ir_d;
  logic          acc;

  logic [DW-1:0] ic_x, ir_x, w_x, h_x, cr_x, cc_x, ir_n;
  logic          col0, norm;
  c3f_ctrl_t     ctrl;
  logic [23:0]   pix;

  logic [47:0]   mem_q [MAX_WIDTH];
  logic [47:0]   rd_q, fwd_q, rd_eff, wr_data;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  logic          s1_valid_q;
  logic [AW-1:0] s1_addr_q;
  logic [23:0]   s1_pix_q;
  c3f_ctrl_t     s1_ctrl_q;
  logic          hit_q;

  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  assign in_stall_o = clr_q ||
                      (({1'b0, q_level_i} + (LW+1)'(s1_valid_q)) >= (LW+1)'(DEPTH));
  assign acc = in_valid_i && !in_stall_o;

  assign pix = in_item_i.flush ? 24'd0 :
               {in_item_i.pixel_blue, in_item_i.pixel_green, in_item_i.pixel_red};

  always_comb begin
    ic_x = DW'(ic_q);
    ir_x = DW'(ir_q);
    w_x  = DW'(img_w_i);
    h_x  = DW'(img_h_i);
    col0 = (ic_q == '0) && (ir_x >= DW'(2));
    norm = (ic_q != '0) && (ir_x >= DW'(1));
    cr_x = col0 ? ir_x - DW'(2) : ir_x - DW'(1);
    cc_x = col0 ? w_x - DW'(1) : ic_x - DW'(1);
    ctrl.col0   = col0;
    ctrl.emit   = (col0 || norm) && (cr_x < h_x);
    ctrl.top    = (cr_x == '0);
    ctrl.bottom = (cr_x + DW'(1)) >= h_x;
    ctrl.left   = (cc_x == '0);
    ctrl.right  = (cc_x + DW'(1)) >= w_x;
    ctrl.last   = ctrl.emit && (cr_x == h_x - DW'(1)) && (cc_x == w_x - DW'(1));
    if ((ic_x + DW'(1)) >= w_x) begin
      ic_d = '0;
      ir_n = ir_x + DW'(1);
    end else begin
      ic_d = ic_q + AW'(1);
      ir_n = ir_x;
    end
    // Restart the frame after its last result or when the row count runs away.
    if (ctrl.last || (ir_n > h_x + DW'(1))) begin
      ic_d = '0;
      ir_n = '0;
    end
    ir_d = ir_n[RW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q       <= '0;
      ir_q       <= '0;
      s1_valid_q <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        ic_q <= ic_d;
        ir_q <= ir_d;
      end
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_WIDTH-1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // Stored word: upper line in the high half, middle line in the low half.
  assign rd_eff  = hit_q ? fwd_q : rd_q;
  assign wr_en   = clr_q || s1_valid_q;
  assign wr_addr = clr_q ? clr_addr_q : s1_addr_q;
  assign wr_data = clr_q ? 48'd0 : {rd_eff[23:0], s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (acc) begin
      rd_q      <= mem_q[ic_q];
      // Forward the write that lands on the same edge as this read.
      hit_q     <= s1_valid_q && (s1_addr_q == ic_q);
      fwd_q     <= wr_data;
      s1_addr_q <= ic_q;
      s1_pix_q  <= pix;
      s1_ctrl_q <= ctrl;
    end
  end

  assign push_o        = s1_valid_q;
  assign entry_o.up    = rd_eff[47:24];
  assign entry_o.mid   = rd_eff[23:0];
  assign entry_o.pix   = s1_pix_q;
  assign entry_o.ctrl  = s1_ctrl_q;

endmodule

// ===== rtl/core/c3f_queue.sv =====
// c3f_queue: short queue of classified transactions between front and back.
// Depends on c3f_pkg.
module c3f_queue
  import c3f_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  c3f_entry_t                 entry_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output c3f_entry_t                 entry_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH+1);

  c3f_entry_t    slot_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [LW-1:0] level_q;
  logic          do_pop;

  assign valid_o = (level_q != '0);
  assign entry_o = slot_q[rp_q];
  assign level_o = level_q;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + PW'(1);
      end
      level_q <= level_q + LW'(push_i) - LW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/core/c3f_back.sv =====
// c3f_back: 3x3 window, kernel multiply, sum and saturation, output register.
// Depends on c3f_pkg.
module c3f_back
  import c3f_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  c3f_entry_t            entry_i,
  output logic                  pop_o,
  input  logic                  colour_mode_i,
  input  logic [CFG_DATA_W-1:0] coef_top_i,
  input  logic [CFG_DATA_W-1:0] coef_middle_i,
  input  logic [CFG_DATA_W-1:0] coef_bottom_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o
);

  logic [23:0] win_q [9];
  logic [23:0] win_d [9];
  logic [23:0] taps  [9];

  logic               t_valid_q, p_valid_q, o_valid_q;
  logic               t_last_q, p_last_q;
  logic [23:0]        taps_q [9];
  logic signed [16:0] prod_q [3][9];
  logic signed [7:0]  coef   [9];
  logic signed [20:0] sum    [3];
  out_item_t          out_q;
  logic               o_rdy, p_rdy, t_rdy;

  assign o_rdy = !o_valid_q || !out_stall_i;
  assign p_rdy = !p_valid_q || o_rdy;
  assign t_rdy = !t_valid_q || p_rdy;
  assign pop_o = valid_i && t_rdy;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[3*r]   = win_q[3*r+1];
      win_d[3*r+1] = win_q[3*r+2];
    end
    win_d[2] = entry_i.up;
    win_d[5] = entry_i.mid;
    win_d[8] = entry_i.pix;
    for (int k = 0; k < 9; k++) begin
      taps[k] = win_d[k];
    end
    // Column zero finishes the previous row: its window has not shifted yet.
    if (entry_i.ctrl.col0) begin
      for (int r = 0; r < 3; r++) begin
        taps[3*r]   = win_q[3*r+1];
        taps[3*r+1] = win_q[3*r+2];
        taps[3*r+2] = '0;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (entry_i.ctrl.top)    taps[k]     = '0;
      if (entry_i.ctrl.bottom) taps[6+k]   = '0;
      if (entry_i.ctrl.left)   taps[3*k]   = '0;
      if (entry_i.ctrl.right)  taps[3*k+2] = '0;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[c]   = coef_top_i[8*c +: 8];
      coef[3+c] = coef_middle_i[8*c +: 8];
      coef[6+c] = coef_bottom_i[8*c +: 8];
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sum[ch] = sum[ch] + 21'(prod_q[ch][k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else begin
      if (t_rdy) begin
        t_valid_q <= pop_o && entry_i.ctrl.emit;
      end
      if (pop_o) begin
        for (int k = 0; k < 9; k++) begin
          win_q[k] <= win_d[k];
        end
      end
      if (p_rdy) begin
        p_valid_q <= t_valid_q;
      end
      if (o_rdy) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && t_rdy) begin
      for (int k = 0; k < 9; k++) begin
        taps_q[k] <= taps[k];
      end
      t_last_q <= entry_i.ctrl.last;
    end
    if (p_rdy && t_valid_q) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int k = 0; k < 9; k++) begin
          prod_q[ch][k] <= 17'(coef[k] * $signed({1'b0, taps_q[k][8*ch +: 8]}));
        end
      end
      p_last_q <= t_last_q;
    end
    if (o_rdy && p_valid_q) begin
      out_q.out_red   <= c3f_saturate(sum[0]);
      out_q.out_green <= colour_mode_i ? c3f_saturate(sum[1]) : 8'd0;
      out_q.out_blue  <= colour_mode_i ? c3f_saturate(sum[2]) : 8'd0;
      out_q.out_last  <= p_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== test/conv3x3_image_filter_tb.sv =====
// conv3x3_image_filter_tb: self-checking testbench of the streaming 3x3 image filter.
// Random and directed frames, a line-buffer predictor and an in-order result scoreboard.
// Depends on c3f_pkg and conv3x3_image_filter.
`timescale 1ns / 1ps

module conv3x3_image_filter_tb;
  import c3f_pkg::*;

  localparam int unsigned LINE_MAX  = 1024;
  localparam int unsigned ROW_MAX   = 1024;
  localparam int unsigned DRAIN_CYC = 20;
  localparam int unsigned CYC_LIMIT = 600000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_item_o;

  conv3x3_image_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  in_item_t  pixel_q[$];
  out_item_t filtered_q[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned mismatches;
  int unsigned cycles;
  bit          in_taken;

  // Shadow of the filter: registers and line-buffer state.
  logic [10:0] img_w_reg, img_h_reg;
  logic        rgb_mode;
  logic [23:0] coef_row[3];
  logic [23:0] line_up[LINE_MAX];
  logic [23:0] line_mid[LINE_MAX];
  logic [23:0] win[9];
  logic [23:0] tap_pix[9];
  int unsigned col_pos, row_pos;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] filter_chan(int unsigned sh);
    int sum;
    int unsigned k;
    logic [7:0] cb;
    sum = 0;
    for (k = 0; k < 9; k++) begin
      cb = coef_row[k / 3][8 * (k % 3) +: 8];
      sum += $signed(cb) * int'(tap_pix[k][sh +: 8]);
    end
    if (sum < 0) return 8'd0;
    sum = sum / 16;
    return (sum > 255) ? 8'd255 : sum[7:0];
  endfunction

  task automatic filter_step(input in_item_t it);
    int unsigned w, h, cr, cc, k;
    logic [23:0] v, up, mid;
    bit cand, last;
    out_item_t res;
    w = (img_w_reg == 0) ? 1 : ((img_w_reg > LINE_MAX) ? LINE_MAX : img_w_reg);
    h = (img_h_reg == 0) ? 1 : ((img_h_reg > ROW_MAX) ? ROW_MAX : img_h_reg);
    v = it.flush ? 24'd0 : {it.pixel_blue, it.pixel_green, it.pixel_red};
    cand = 0;
    last = 0;
    cr = 0;
    cc = 0;
    up = 24'd0;
    mid = 24'd0;
    // Column 0 completes the right-most pixel of the row before last.
    if (col_pos == 0 && row_pos >= 2) begin
      for (k = 0; k < 3; k++) begin
        tap_pix[k * 3]     = win[k * 3 + 1];
        tap_pix[k * 3 + 1] = win[k * 3 + 2];
        tap_pix[k * 3 + 2] = 24'd0;
      end
      cr = row_pos - 2;
      cc = w - 1;
      cand = 1;
    end
    if (col_pos < LINE_MAX) begin
      up = line_up[col_pos];
      mid = line_mid[col_pos];
      line_up[col_pos] = mid;
      line_mid[col_pos] = v;
    end
    for (k = 0; k < 3; k++) begin
      win[k * 3]     = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = v;
    if (col_pos >= 1 && row_pos >= 1) begin
      tap_pix = win;
      cr = row_pos - 1;
      cc = col_pos - 1;
      cand = 1;
    end
    if (cand && cr < h) begin
      // Zero padding outside the image.
      for (k = 0; k < 3; k++) begin
        if (cr == 0) tap_pix[k] = 24'd0;
        if (cr + 1 >= h) tap_pix[6 + k] = 24'd0;
        if (cc == 0) tap_pix[k * 3] = 24'd0;
        if (cc + 1 >= w) tap_pix[k * 3 + 2] = 24'd0;
      end
      last = (cr == h - 1) && (cc == w - 1);
      res.out_red   = filter_chan(0);
      res.out_green = rgb_mode ? filter_chan(8) : 8'd0;
      res.out_blue  = rgb_mode ? filter_chan(16) : 8'd0;
      res.out_last  = last;
      filtered_q.push_back(res);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    if (last || row_pos > h + 1) begin
      col_pos = 0;
      row_pos = 0;
    end
    row_pos = row_pos & 32'h7FF;
  endtask

  // Driver: present a new transaction only once the previous one is taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        in_taken = 0;
        if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pixel_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: predict on accepted input, check accepted output.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        filter_step(in_item_i);
        in_taken = 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %h", out_item_o);
        end else begin
          want = filtered_q.pop_front();
          if (want !== out_item_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: want r=%h g=%h b=%h last=%b got r=%h g=%h b=%h last=%b",
                       want.out_red, want.out_green, want.out_blue, want.out_last,
                       out_item_o.out_red, out_item_o.out_green, out_item_o.out_blue,
                       out_item_o.out_last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("conv3x3_image_filter regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w_reg = data[10:0];
      CFG_IMAGE_HEIGHT: img_h_reg = data[10:0];
      CFG_COLOUR_MODE:  rgb_mode = data[0];
      CFG_COEF_TOP:     coef_row[0] = data;
      CFG_COEF_MIDDLE:  coef_row[1] = data;
      CFG_COEF_BOTTOM:  coef_row[2] = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_pixel(input logic [7:0] r, g, b, input logic f);
    in_item_t it;
    it.pixel_red = r;
    it.pixel_green = g;
    it.pixel_blue = b;
    it.flush = f;
    pixel_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_valid_i || filtered_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  // One frame with random pixels, occasional early flush and stray pixels in the tail.
  task automatic push_frame(input int unsigned w, input int unsigned h, output int unsigned n);
    int unsigned i;
    n = w * h + w + 1;
    for (i = 0; i < w * h; i++)
      push_pixel($urandom, $urandom, $urandom, $urandom_range(0, 15) == 0);
    for (i = 0; i <= w; i++)
      push_pixel($urandom, $urandom, $urandom, $urandom_range(0, 9) != 0);
  endtask

  function automatic logic [23:0] rand_coefs();
    logic [23:0] c;
    c = $urandom;
    if ($urandom_range(0, 1)) c = c & 24'h1F1F1F;
    return c;
  endfunction

  initial begin
    int unsigned i, mode, ph, got, n;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    in_taken = 0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 23;
    recv_idle_pct = 45;
    img_w_reg = 11'd1024;
    img_h_reg = 11'd1024;
    rgb_mode = 1'b0;
    coef_row[0] = COEF_TOP_RST;
    coef_row[1] = COEF_MIDDLE_RST;
    coef_row[2] = COEF_BOTTOM_RST;
    for (i = 0; i < LINE_MAX; i++) begin
      line_up[i] = 24'd0;
      line_mid[i] = 24'd0;
    end
    for (i = 0; i < 9; i++) win[i] = 24'd0;
    col_pos = 0;
    row_pos = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset kernel on a 3x3 frame of extremes with an early flush.
    cfg_write(CFG_IMAGE_WIDTH, 24'd3);
    cfg_write(CFG_IMAGE_HEIGHT, 24'd3);
    for (i = 0; i < 9; i++)
      push_pixel(i[0] ? 8'h00 : 8'hFF, i[0] ? 8'h00 : 8'hFF, 8'hFF, i == 4);
    for (i = 0; i < 4; i++) push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    wait_idle();
    // Directed: extreme coefficients in RGB on a 2x2 frame.
    cfg_write(CFG_IMAGE_WIDTH, 24'd2);
    cfg_write(CFG_IMAGE_HEIGHT, 24'd2);
    cfg_write(CFG_COLOUR_MODE, 24'd1);
    cfg_write(CFG_COEF_TOP, 24'h7F7F7F);
    cfg_write(CFG_COEF_MIDDLE, 24'h808080);
    cfg_write(CFG_COEF_BOTTOM, 24'h7F807F);
    for (i = 0; i < 4; i++) push_pixel(8'hFF, 8'h00, 8'hFF, i == 3);
    for (i = 0; i < 3; i++) push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    wait_idle();

    // Size extremes: zero acts as one, oversize acts as the maximum.
    cfg_write(CFG_IMAGE_WIDTH, 24'd0);
    cfg_write(CFG_IMAGE_HEIGHT, 24'd0);
    cfg_write(CFG_COEF_MIDDLE, 24'h001000);
    push_frame(1, 1, n);
    wait_idle();
    cfg_write(CFG_IMAGE_WIDTH, 24'h7FF);
    cfg_write(CFG_IMAGE_HEIGHT, 24'h7FF);
    cfg_write(CFG_COLOUR_MODE, 24'd0);
    // Part of a wide first row; the next setting picks up mid-frame.
    for (i = 0; i < 40; i++) push_pixel($urandom, $urandom, $urandom, 1'b0);
    wait_idle();

    // Random: three idle profiles, several kernel and size settings each.
    for (mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 23 : ((mode == 1) ? 45 : 0);
      recv_idle_pct = (mode == 0) ? 45 : ((mode == 1) ? 23 : 0);
      for (ph = 0; ph < 3; ph++) begin
        cfg_write(CFG_IMAGE_WIDTH, $urandom_range(1, 8));
        cfg_write(CFG_IMAGE_HEIGHT, $urandom_range(1, 6));
        cfg_write(CFG_COLOUR_MODE, $urandom_range(0, 1));
        cfg_write(CFG_COEF_TOP, rand_coefs());
        cfg_write(CFG_COEF_MIDDLE, rand_coefs());
        cfg_write(CFG_COEF_BOTTOM, rand_coefs());
        got = 0;
        while (got < 105) begin
          push_frame((img_w_reg == 0) ? 1 : img_w_reg, (img_h_reg == 0) ? 1 : img_h_reg, n);
          got += n;
          // Hold off the sender once until the pipeline is empty.
          if (mode == 0 && ph == 1 && got == n) wait_drained();
        end
        // Stray pixels leave the next setting to start mid-frame.
        if ($urandom_range(0, 2) == 0)
          for (i = 0; i < 3; i++) push_pixel($urandom, $urandom, $urandom, 1'b0);
        wait_idle();
      end
    end

    wait_idle();
    if (mismatches == 0 && filtered_q.size() == 0) begin
      $display("conv3x3_image_filter regression: pass");
    end else begin
      $display("conv3x3_image_filter regression: fail");
    end
    $finish;
  end

endmodule
